// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ede_pkg.sv
package ede_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int DIST_W      = 7;
	localparam int DIST_MAX    = 127;

	typedef enum logic [1:0] {
		OP_REF = 2'd0,
		OP_QRY = 2'd1,
		OP_FIN = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
	} ede_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} ede_out_t;

	// query byte traveling down the cell chain
	typedef struct packed {
		logic       valid;
		logic [7:0] qbyte;
	} qlink_t;

endpackage

// File: hdl/ede_cell.sv
module ede_cell #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  logic           ref_we,
	input  logic [7:0]     ref_byte,
	input  ede_pkg::qlink_t left_link,
	input  logic [CW-1:0]  left_cost,
	input  logic [CW-1:0]  left_corner,
	output ede_pkg::qlink_t right_link,
	output logic [CW-1:0]  cost,
	output logic [CW-1:0]  corner
);
	import ede_pkg::*;

	localparam logic [CW-1:0] INIT = CW'(IDX + 1);

	logic [7:0]    ref_q;
	logic [CW-1:0] cost_q;
	logic [CW-1:0] old_q;
	logic          valid_q;
	logic [7:0]    qbyte_q;
	logic [CW-1:0] m1;
	logic [CW-1:0] m2;
	logic [CW-1:0] next_cost;

	always_comb begin
		m1 = (left_cost < cost_q) ? left_cost : cost_q;
		m2 = (m1 < left_corner) ? m1 : left_corner;
		if (ref_q == left_link.qbyte) begin
			next_cost = left_corner;
		end else begin
			next_cost = m2 + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q  <= INIT;
			valid_q <= 1'b0;
		end else begin
			valid_q <= left_link.valid;
			if (clear) begin
				cost_q <= INIT;
			end else if (left_link.valid) begin
				cost_q <= next_cost;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_q <= ref_byte;
		end
		qbyte_q <= left_link.qbyte;
		old_q   <= cost_q;
	end

	assign right_link.valid = valid_q;
	assign right_link.qbyte = qbyte_q;
	assign cost             = cost_q;
	assign corner           = old_q;

endmodule

// File: hdl/edit_distance_engine_unit.sv
// channel  | handshake          | payload            | notes
// ---------+--------------------+--------------------+------------------------------
// item     | start && !busy     | ede_in_t  item     | op/ch
// result   | done (1 cycle)     | ede_out_t result   | one per finish transaction
//
// Load and query bytes are taken whenever busy is low; query bytes may follow back to back,
// each one rippling down the cell row as a wavefront, one cell per cycle.
// A finish holds busy until the wavefront leaves the row, then done pulses the cycle after.
// Reset clears lengths and overflow flag and sets every cell's cost to its initial value; no clearing pass.
// The receiver cannot stall: result is valid only while done is high.
`include "assert_macros.svh"

module edit_distance_engine_unit #(
	parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ede_pkg::ede_in_t  item,
	output logic              busy,
	output logic              done,
	output ede_pkg::ede_out_t result
);
	import ede_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int IW = $clog2(MAX_LEN);
	localparam int DW = (CW > DIST_W) ? CW : DIST_W;

	state_t        state_q, state_d;
	logic [CW-1:0] rlen_q;
	logic [CW-1:0] qlen_q;
	logic          ovf_q;
	logic          done_q;
	ede_out_t      result_q;

	logic          accept;
	logic          is_ref;
	logic          is_qry;
	logic          is_fin;
	logic          ref_ok;
	logic          q_go;
	logic          clear;
	logic          chain_active;
	logic [CW-1:0] last_idx;
	logic [CW-1:0] dist_sel;
	logic [DW-1:0] dist_ext;

	qlink_t        lnk   [MAX_LEN+1];
	logic [CW-1:0] costs [MAX_LEN];
	logic [CW-1:0] olds  [MAX_LEN];
	logic [CW-1:0] head_cost;
	logic [MAX_LEN-1:0] vld;
	logic [MAX_LEN-1:0] ref_we;

	assign busy   = (state_q == ST_DRAIN);
	assign accept = start && !busy;
	assign is_ref = accept && (item.op == OP_REF);
	assign is_qry = accept && (item.op == OP_QRY);
	assign is_fin = accept && (item.op == OP_FIN);
	// reference bytes after the first query byte are dropped silently
	assign ref_ok = is_ref && (qlen_q == '0);
	assign q_go   = is_qry && (qlen_q < CW'(MAX_LEN));

	assign lnk[0].valid = q_go;
	assign lnk[0].qbyte = item.ch;
	assign head_cost    = qlen_q + 1'b1;

	genvar j;
	generate
		for (j = 0; j < MAX_LEN; j++) begin : g_cell
			assign ref_we[j] = ref_ok && (rlen_q == CW'(j));
			assign vld[j]    = lnk[j+1].valid;
			if (j == 0) begin : g_head
				ede_cell #(.CW(CW), .IDX(j)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.clear      (clear),
					.ref_we     (ref_we[j]),
					.ref_byte   (item.ch),
					.left_link  (lnk[j]),
					.left_cost  (head_cost),
					.left_corner(qlen_q),
					.right_link (lnk[j+1]),
					.cost       (costs[j]),
					.corner     (olds[j])
				);
			end else begin : g_body
				ede_cell #(.CW(CW), .IDX(j)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.clear      (clear),
					.ref_we     (ref_we[j]),
					.ref_byte   (item.ch),
					.left_link  (lnk[j]),
					.left_cost  (costs[j-1]),
					.left_corner(olds[j-1]),
					.right_link (lnk[j+1]),
					.cost       (costs[j]),
					.corner     (olds[j])
				);
			end
		end
	endgenerate

	assign chain_active = |vld;
	assign last_idx     = rlen_q - 1'b1;
	assign dist_sel     = (rlen_q == '0) ? qlen_q : costs[last_idx[IW-1:0]];
	assign dist_ext     = DW'(dist_sel);

	always_comb begin
		state_d = state_q;
		clear   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (is_fin) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!chain_active) begin
					clear   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rlen_q  <= '0;
			qlen_q  <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= clear;
			if (clear) begin
				rlen_q <= '0;
				qlen_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				if (ref_ok) begin
					if (rlen_q < CW'(MAX_LEN)) begin
						rlen_q <= rlen_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				if (is_qry) begin
					if (q_go) begin
						qlen_q <= qlen_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			result_q.distance <= (dist_ext > DW'(DIST_MAX)) ? DIST_W'(DIST_MAX)
				: dist_ext[DIST_W-1:0];
			result_q.overflow <= ovf_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q, "done held longer than one cycle")
	`ASSERT_IMPL(a_done_from_drain, clk, arst_n, done_q, $past(state_q == ST_DRAIN), "done without drain")
	`ASSERT_IMPL(a_done_cleared, clk, arst_n, done_q,
		(rlen_q == '0) && (qlen_q == '0) && !ovf_q, "strings not cleared after report")
	`ASSERT_IMPL(a_rlen_bound, clk, arst_n, 1'b1, rlen_q <= CW'(MAX_LEN), "reference length out of range")

endmodule
